FILE: rtl/pow_nonce_check_unit_defines.svh
// Assertion macros for the nonce check unit
`ifndef POW_NONCE_CHECK_UNIT_DEFINES_SVH
`define POW_NONCE_CHECK_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PNC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define PNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/pnc_pkg.sv
// Package for the nonce check unit: SHA-256 constants, types and round functions
`default_nettype none
package pnc_pkg;
  localparam int unsigned Rounds = 64;
  localparam int unsigned CfgAddrW = 6;

  typedef enum logic [2:0] {
    REG_DIFFICULTY = 3'd0,
    REG_BLOCK_NUM  = 3'd1,
    REG_PREV_0     = 3'd2,
    REG_PREV_1     = 3'd3,
    REG_PREV_2     = 3'd4,
    REG_PREV_3     = 3'd5
  } reg_idx_t;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } state_t;

  // round stage control and payload travelling together
  typedef struct packed {
    logic          vld;
    logic [63:0]   nonce;
    state_t        st;
    word_t [15:0]  w;
  } stage_t;

  localparam word_t [0:63] RoundK = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam state_t InitH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // one compression round on a state with its schedule word
  function automatic state_t sha_round(input state_t s, input word_t k, input word_t wi);
    word_t s1, ch, t1, s0, mj;
    state_t r;
    s1 = rotr(s.e, 6) ^ rotr(s.e, 11) ^ rotr(s.e, 25);
    ch = (s.e & s.f) ^ (~s.e & s.g);
    t1 = s.h + s1 + ch + k + wi;
    s0 = rotr(s.a, 2) ^ rotr(s.a, 13) ^ rotr(s.a, 22);
    mj = (s.a & s.b) ^ (s.a & s.c) ^ (s.b & s.c);
    r.a = t1 + s0 + mj;
    r.b = s.a; r.c = s.b; r.d = s.c;
    r.e = s.d + t1;
    r.f = s.e; r.g = s.f; r.h = s.g;
    sha_round = r;
  endfunction

  // next schedule word from a sliding window (w[0] oldest)
  function automatic word_t sched_next(input word_t [15:0] w);
    word_t s0, s1;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    sched_next = w[0] + s0 + w[9] + s1;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/pnc_round_stage.sv
// One registered SHA-256 round with its message schedule step
`default_nettype none
module pnc_round_stage
  import pnc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   advance,
  input  wire word_t  k,
  input  stage_t      din,
  output stage_t      dout
);
  stage_t res;

  // compute round and slide the schedule window
  always_comb begin
    res.vld   = din.vld;
    res.nonce = din.nonce;
    res.st    = sha_round(din.st, k, din.w[0]);
    for (int i = 0; i < 15; i++) begin
      res.w[i] = din.w[i + 1];
    end
    res.w[15] = sched_next(din.w);
  end

  // hold on stall, advance otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (advance) begin
      dout.vld <= res.vld;
    end
    if (advance) begin
      dout.nonce <= res.nonce;
      dout.st    <= res.st;
      dout.w     <= res.w;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pnc_regs.sv
// Configuration register file on the APB-style port
`default_nettype none
module pnc_regs
  import pnc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [63:0]         pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  output logic [7:0]               difficulty_bits,
  output logic [63:0]              block_number,
  output logic [3:0][63:0]         parent_hash
);
  logic     wr;
  reg_idx_t idx;
  logic     idx_ok;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:3]);
  assign idx_ok = (paddr[2:0] == 3'd0);

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      difficulty_bits <= 8'd16;
      block_number    <= '0;
      parent_hash     <= '0;
    end else if (wr && idx_ok) begin
      case (idx)
        REG_DIFFICULTY: difficulty_bits <= pwdata[7:0];
        REG_BLOCK_NUM:  block_number    <= pwdata;
        REG_PREV_0:     parent_hash[0]  <= pwdata;
        REG_PREV_1:     parent_hash[1]  <= pwdata;
        REG_PREV_2:     parent_hash[2]  <= pwdata;
        REG_PREV_3:     parent_hash[3]  <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      case (idx)
        REG_DIFFICULTY: prdata = {56'd0, difficulty_bits};
        REG_BLOCK_NUM:  prdata = block_number;
        REG_PREV_0:     prdata = parent_hash[0];
        REG_PREV_1:     prdata = parent_hash[1];
        REG_PREV_2:     prdata = parent_hash[2];
        REG_PREV_3:     prdata = parent_hash[3];
        default:        prdata = '0;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pow_nonce_check_unit.sv
// Top level of the proof-of-work nonce check unit
// Usage:
//   Slave stream s_axis_*: one 64-bit candidate nonce per request in tdata.
//   Master stream m_axis_*: one result per nonce; tuser holds the hit flag,
//   tdata holds {digest words 3..0, tried nonce} with the nonce in the low bits.
//   APB-style port sets difficulty, block number and previous hash (8-byte
//   stride); write it only while no nonce is in flight.
// Pipeline: an accepted nonce passes one load stage, 64 round stages, then the
//   output register that finalises and compares.
// Throughput: one nonce per cycle while the output is not stalled; the unrolled
//   64-round pipeline sets this.
// Reset: clears all valid bits, the solved flag and the latched winner, and
//   sets difficulty to 16 with all other registers zero.
// Stall: while the output register holds a result that m_axis_tready does not
//   take, the whole pipeline and the input hold; nothing is lost or repeated.
`default_nettype none
`include "pow_nonce_check_unit_defines.svh"
module pow_nonce_check_unit
  import pnc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [63:0]         s_axis_tdata,   // [63:0] candidate_nonce
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [319:0]             m_axis_tdata,   // [63:0] tried_nonce, [127:64] digest_word_0,
                                                   // [191:128] word_1, [255:192] word_2,
                                                   // [319:256] word_3
  output logic                     m_axis_tuser,   // [0] hit
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [63:0]         pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);
  logic [7:0]       difficulty_bits;
  logic [63:0]      block_number;
  logic [3:0][63:0] parent_hash;
  stage_t           pipe [0:Rounds];
  logic             advance;
  logic             solved;
  logic [63:0]      winning_nonce;
  logic [3:0][63:0] winning_digest;
  state_t           fin;
  logic [255:0]     dig;
  logic [255:0]     mask;
  logic             hit_c;

  pnc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .difficulty_bits, .block_number, .parent_hash
  );

  // whole pipeline moves when the output register is free or being taken
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // load stage: build the message block
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].vld <= 1'b0;
    end else if (advance) begin
      pipe[0].vld <= s_axis_tvalid;
    end
    if (advance) begin
      pipe[0].nonce <= s_axis_tdata;
      pipe[0].st    <= InitH;
      pipe[0].w[0]  <= block_number[63:32];
      pipe[0].w[1]  <= block_number[31:0];
      for (int i = 0; i < 4; i++) begin
        pipe[0].w[2 + 2 * i] <= parent_hash[i][63:32];
        pipe[0].w[3 + 2 * i] <= parent_hash[i][31:0];
      end
      pipe[0].w[10] <= s_axis_tdata[63:32];
      pipe[0].w[11] <= s_axis_tdata[31:0];
      pipe[0].w[12] <= 32'h80000000;
      pipe[0].w[13] <= 32'd0;
      pipe[0].w[14] <= 32'd0;
      pipe[0].w[15] <= 32'd384;
    end
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    pnc_round_stage u_stage (
      .clk, .rst, .advance, .k(RoundK[r]), .din(pipe[r]), .dout(pipe[r + 1])
    );
  end

  // finalise digest and compare leading bits
  always_comb begin
    fin.a = pipe[Rounds].st.a + InitH.a;
    fin.b = pipe[Rounds].st.b + InitH.b;
    fin.c = pipe[Rounds].st.c + InitH.c;
    fin.d = pipe[Rounds].st.d + InitH.d;
    fin.e = pipe[Rounds].st.e + InitH.e;
    fin.f = pipe[Rounds].st.f + InitH.f;
    fin.g = pipe[Rounds].st.g + InitH.g;
    fin.h = pipe[Rounds].st.h + InitH.h;
    dig   = {fin.a, fin.b, fin.c, fin.d, fin.e, fin.f, fin.g, fin.h};
    mask  = ~({256{1'b1}} >> difficulty_bits);
    hit_c = ((dig & mask) == '0);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= pipe[Rounds].vld;
    end
    if (advance) begin
      m_axis_tuser  <= hit_c;
      m_axis_tdata  <= {dig[63:0], dig[127:64], dig[191:128], dig[255:192],
                        pipe[Rounds].nonce};
    end
  end

  // latch the winning trial
  always_ff @(posedge clk) begin
    if (rst) begin
      solved         <= 1'b0;
      winning_nonce  <= '0;
      winning_digest <= '0;
    end else if (advance && pipe[Rounds].vld && hit_c) begin
      solved         <= 1'b1;
      winning_nonce  <= pipe[Rounds].nonce;
      winning_digest <= {dig[63:0], dig[127:64], dig[191:128], dig[255:192]};
    end
  end

  `PNC_ASSERT_IMP(a_stall_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")
  `PNC_ASSERT_NEXT(a_solved_sticky, solved, solved, "solved flag dropped")
  `PNC_ASSERT_IMP(a_win_matches, m_axis_tvalid && m_axis_tuser, solved && winning_nonce == m_axis_tdata[63:0] && winning_digest == m_axis_tdata[319:64], "winner not latched")
endmodule
`default_nettype wire

FILE: tb/pow_nonce_check_scoreboard.sv
// Scoreboard for the nonce check unit: SHA-256 header predictor and result comparison
`timescale 1ns / 1ps
module pow_nonce_check_scoreboard
  import pnc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [63:0]         s_axis_tdata,   // [63:0] candidate_nonce
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [319:0]        m_axis_tdata,   // [63:0] tried_nonce, [319:64] digest words 0..3
  input  wire logic                m_axis_tuser,   // [0] hit
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic                pready,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [63:0]         pwdata,
  output int                       mismatches,
  output int                       outstanding
);

  typedef struct {
    logic        hit;
    logic [63:0] nonce;
    logic [63:0] dig [4];
  } trial_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [7:0]  difficulty;
  logic [63:0] block_num;
  logic [63:0] parent_hash [4];
  trial_t      awaited_results [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // hash the padded header for one nonce and judge it against the difficulty
  function automatic trial_t predict_trial(input logic [63:0] nonce);
    logic [31:0]  w [64];
    logic [31:0]  v [8];
    logic [31:0]  t1, t2;
    logic [255:0] digest;
    trial_t       r;
    w[0] = block_num[63:32];
    w[1] = block_num[31:0];
    for (int i = 0; i < 4; i++) begin
      w[2 + 2 * i] = parent_hash[i][63:32];
      w[3 + 2 * i] = parent_hash[i][31:0];
    end
    w[10] = nonce[63:32];
    w[11] = nonce[31:0];
    w[12] = 32'h80000000;
    w[13] = '0;
    w[14] = '0;
    w[15] = 32'd384;
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = IV_TAB;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      digest[255 - 32 * i -: 32] = IV_TAB[i] + v[i];
    for (int i = 0; i < 4; i++)
      r.dig[i] = digest[255 - 64 * i -: 64];
    r.nonce = nonce;
    r.hit = (difficulty == 0) || ((digest >> (256 - int'(difficulty))) == '0);
    return r;
  endfunction

  assign outstanding = awaited_results.size();

  // track register writes, queue predictions, compare results
  always @(posedge clk) begin
    trial_t      exp_r;
    logic [63:0] got_w;
    int          errs;
    errs = 0;
    if (rst) begin
      difficulty   <= 8'd16;
      block_num    <= '0;
      parent_hash  <= '{default: '0};
      mismatches   <= 0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[5:3]))
          REG_DIFFICULTY: difficulty     <= pwdata[7:0];
          REG_BLOCK_NUM:  block_num      <= pwdata;
          REG_PREV_0:     parent_hash[0] <= pwdata;
          REG_PREV_1:     parent_hash[1] <= pwdata;
          REG_PREV_2:     parent_hash[2] <= pwdata;
          REG_PREV_3:     parent_hash[3] <= pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.insert(awaited_results.size(), predict_trial(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, nonce %h", $realtime, m_axis_tdata[63:0]);
          errs++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (m_axis_tuser !== exp_r.hit) begin
            $display("%0t: hit expected %b actual %b (nonce %h)", $realtime,
                     exp_r.hit, m_axis_tuser, exp_r.nonce);
            errs++;
          end
          if (m_axis_tdata[63:0] !== exp_r.nonce) begin
            $display("%0t: tried_nonce expected %h actual %h", $realtime,
                     exp_r.nonce, m_axis_tdata[63:0]);
            errs++;
          end
          for (int i = 0; i < 4; i++) begin
            got_w = m_axis_tdata[64 * (i + 1) +: 64];
            if (got_w !== exp_r.dig[i]) begin
              $display("%0t: digest_word_%0d expected %h actual %h", $realtime, i,
                       exp_r.dig[i], got_w);
              errs++;
            end
          end
        end
      end
      mismatches <= mismatches + errs;
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the nonce check unit testbench: stimulus, register setup and verdict
`timescale 1ns / 1ps
module testbench;
  import pnc_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata;   // [63:0] candidate_nonce
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [319:0]        m_axis_tdata;   // [63:0] tried_nonce, [319:64] digest words 0..3
  logic                m_axis_tuser;   // [0] hit
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;
  int                  mismatches;
  int                  outstanding;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  pow_nonce_check_unit uut (.*);

  pow_nonce_check_scoreboard scoreboard (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall the result side at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // offer one nonce, idling first at random, and hold until taken
  task automatic send_nonce(input logic [63:0] nonce);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nonce;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CfgAddrW-1:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [CfgAddrW-1:0] reg_addr(input reg_idx_t idx);
    return CfgAddrW'(8 * int'(idx));
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // load a whole header setting; upper bits of the difficulty write are junk
  task automatic load_header(input logic [7:0] diff, input logic [63:0] bnum,
                             input logic [63:0] p0, input logic [63:0] p1,
                             input logic [63:0] p2, input logic [63:0] p3);
    reg_write(reg_addr(REG_DIFFICULTY), {56'(rand64() >> 8), diff});
    reg_write(reg_addr(REG_BLOCK_NUM), bnum);
    reg_write(reg_addr(REG_PREV_0), p0);
    reg_write(reg_addr(REG_PREV_1), p1);
    reg_write(reg_addr(REG_PREV_2), p2);
    reg_write(reg_addr(REG_PREV_3), p3);
  endtask

  initial begin
    logic [7:0] diff;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cycle_count    = 0;
    send_idle_pct  = 23;
    recv_stall_pct = 72;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: field extremes and single bits
    send_nonce('0);
    send_nonce('1);
    send_nonce(64'haaaa_aaaa_aaaa_aaaa);
    send_nonce(64'h5555_5555_5555_5555);
    send_nonce(64'd1);
    send_nonce(64'h8000_0000_0000_0000);
    drain();

    // zero difficulty: every trial hits, winner overwritten each time
    load_header(8'd0, '0, '0, '0, '0, '0);
    repeat (4) send_nonce(rand64());
    drain();

    // top difficulty: nothing hits
    load_header(8'd255, '1, '1, '1, '1, '1);
    send_nonce('0);
    send_nonce('1);
    send_nonce(rand64());
    drain();

    // unknown register slots must leave the setting alone
    reg_write(CfgAddrW'(48), '1);
    reg_write(CfgAddrW'(56), '0);
    reg_write(reg_addr(REG_DIFFICULTY), 64'd1);
    repeat (6) send_nonce(rand64());
    drain();

    // random part: three idling regimes, several header settings each
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 23 : (phase == 1) ? 72 : 0;
      recv_stall_pct = (phase == 0) ? 72 : (phase == 1) ? 23 : 0;
      for (int chunk = 0; chunk < 3; chunk++) begin
        case ($urandom_range(9))
          0:       diff = 8'd0;
          1:       diff = 8'd255;
          2:       diff = 8'd64;
          default: diff = 8'($urandom_range(10, 1));
        endcase
        load_header(diff, rand64(), rand64(), rand64(), rand64(), rand64());
        repeat (200) send_nonce(rand64());
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pnc_pkg.sv
rtl/pnc_round_stage.sv
rtl/pnc_regs.sv
rtl/pow_nonce_check_unit.sv
tb/pow_nonce_check_scoreboard.sv
tb/testbench.sv
